// ===== rtl/held_karp_tour_solver_assert.svh =====
// Assertion macros shared by the tour solver checks.
`ifndef HELD_KARP_TOUR_SOLVER_ASSERT_SVH
`define HELD_KARP_TOUR_SOLVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HKTS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hkts check failed");

// Next-cycle implication, disabled during reset.
`define HKTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hkts check failed");

`endif

// ===== rtl/hkts_pkg.sv =====
`default_nettype none

package hkts_pkg;

  // Default sizing
  localparam int MAX_VERTICES_DFLT = 16;
  localparam int WEIGHT_BITS_DFLT  = 16;

  // Fixed field widths
  localparam int VERTEX_BITS   = 4;
  localparam int EDGE_BITS     = 16;
  localparam int LENGTH_BITS   = 20;
  localparam int S_DATA_BITS   = 2 * VERTEX_BITS + EDGE_BITS;
  localparam int M_DATA_BITS   = VERTEX_BITS + LENGTH_BITS;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 5;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_VERTEX = 1'b1;

  localparam logic [CFG_DATA_BITS-1:0] VERTEX_COUNT_RESET = 5'd16;

  // Control from the stream front end to the solver core
  typedef struct packed {
    logic                   start;
    logic                   wr;
    logic [VERTEX_BITS-1:0] row;
    logic [VERTEX_BITS-1:0] col;
  } solve_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/hkts_solver.sv =====
`default_nettype none

module hkts_solver #(
  parameter int MAX_VERTICES = hkts_pkg::MAX_VERTICES_DFLT,
  parameter int WEIGHT_BITS  = hkts_pkg::WEIGHT_BITS_DFLT
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire hkts_pkg::solve_ctrl_t                      ctrl,
  input  wire logic [WEIGHT_BITS-1:0]                     load_weight,
  input  wire logic [$clog2(MAX_VERTICES+1)-1:0]          vertex_total,
  input  wire logic [$clog2(MAX_VERTICES+1)-1:0]          tour_pos,
  output logic      [$clog2(MAX_VERTICES)-1:0]            tour_vertex,
  output logic      [WEIGHT_BITS+$clog2(MAX_VERTICES):0]  best_cost,
  output logic                                            done
);

  localparam int VB          = $clog2(MAX_VERTICES);
  localparam int NB          = $clog2(MAX_VERTICES + 1);
  localparam int SB          = MAX_VERTICES - 1;
  localparam int LASTS       = MAX_VERTICES - 1;
  localparam int TABLE_DEPTH = (1 << (MAX_VERTICES - 1)) * (MAX_VERTICES - 1);
  localparam int TAB_AW      = $clog2(TABLE_DEPTH);
  localparam int MAT_DEPTH   = 1 << (2 * VB);
  localparam int COST_BITS   = WEIGHT_BITS + VB + 1;
  localparam logic [COST_BITS-1:0] COST_INF = '1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAST_CHK,
    S_SINGLE,
    S_PREV_CHK,
    S_PREV_ACC,
    S_WRITE,
    S_FIN_CHK,
    S_FIN_ACC,
    S_BACK_CHK,
    S_BACK_CMP
  } state_t;

  state_t                state;
  logic [VB-1:0]         s_idx;
  logic [SB-1:0]         full;
  logic [SB-1:0]         set;
  logic [VB-1:0]         last;
  logic [VB-1:0]         prev;
  logic [VB-1:0]         scan;
  logic [VB-1:0]         tail;
  logic [SB-1:0]         remaining;
  logic [NB-1:0]         pass;
  logic [NB-1:0]         count;
  logic [COST_BITS-1:0]  cur_min;
  logic [COST_BITS-1:0]  rem;
  logic [VB-1:0]         tour_buffer [MAX_VERTICES];

  logic [WEIGHT_BITS-1:0] dist_mem [MAT_DEPTH];
  logic [COST_BITS-1:0]   cost_mem [TABLE_DEPTH];
  logic [WEIGHT_BITS-1:0] mat_q;
  logic [COST_BITS-1:0]   tab_q;

  logic [VB-1:0]         mat_row;
  logic [VB-1:0]         mat_col;
  logic [SB-1:0]         tab_set;
  logic [VB-1:0]         tab_last;
  logic [TAB_AW-1:0]     tab_ra;
  logic [TAB_AW-1:0]     tab_wa;
  logic                  tab_we;

  logic [SB-1:0]         last_bit;
  logic [SB-1:0]         prev_bit;
  logic [SB-1:0]         scan_bit;
  logic [SB-1:0]         pre;
  logic [NB-1:0]         n_minus;
  logic                  last_end;
  logic                  prev_end;
  logic                  scan_end;
  state_t                after_last;

  logic [COST_BITS-1:0]  w_ext;
  logic [COST_BITS-1:0]  alu_a;
  logic [COST_BITS-1:0]  alu_b;
  logic                  alu_sub;
  logic [COST_BITS:0]    alu_res;
  logic [COST_BITS-1:0]  alu_sum;
  logic                  alu_carry;
  logic [COST_BITS-1:0]  cmp_ref;
  logic                  sum_less;
  logic                  tab_inf;
  logic                  back_match;
  logic [COST_BITS-1:0]  best_new;
  logic [NB-1:0]         tb_off;

  // Loop bookkeeping
  assign last_bit   = SB'(1) << last;
  assign prev_bit   = SB'(1) << prev;
  assign scan_bit   = SB'(1) << scan;
  assign pre        = set ^ last_bit;
  assign n_minus    = vertex_total - NB'(1);
  assign last_end   = (last == s_idx - VB'(1));
  assign prev_end   = (prev == s_idx - VB'(1));
  assign scan_end   = (scan == s_idx - VB'(1));
  assign after_last = (last_end && set == full) ? S_FIN_CHK : S_LAST_CHK;

  // Pick the matrix and table read addresses for the step being issued
  always_comb begin
    mat_row  = prev;
    mat_col  = last;
    tab_set  = pre;
    tab_last = prev;
    unique case (state)
      S_LAST_CHK: begin
        mat_row = s_idx;
        mat_col = last;
      end
      S_FIN_CHK: begin
        mat_row  = last;
        mat_col  = s_idx;
        tab_set  = full;
        tab_last = last;
      end
      S_BACK_CHK: begin
        mat_row  = scan;
        mat_col  = tail;
        tab_set  = remaining;
        tab_last = scan;
      end
      default: begin
      end
    endcase
  end

  assign tab_ra = TAB_AW'(tab_set) * TAB_AW'(LASTS) + TAB_AW'(tab_last);
  assign tab_wa = TAB_AW'(set) * TAB_AW'(LASTS) + TAB_AW'(last);
  assign tab_we = (state == S_WRITE);

  // Distance matrix: load port writes, solver reads
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      dist_mem[{VB'(ctrl.row), VB'(ctrl.col)}] <= load_weight;
    end
    mat_q <= dist_mem[{mat_row, mat_col}];
  end

  // Subset cost table
  always_ff @(posedge clk) begin
    if (tab_we) begin
      cost_mem[tab_wa] <= cur_min;
    end
    tab_q <= cost_mem[tab_ra];
  end

  // Shared add/subtract unit: add for relaxation, subtract for the walk back
  always_comb begin
    w_ext     = COST_BITS'(mat_q);
    alu_sub   = (state == S_BACK_CMP);
    alu_a     = alu_sub ? rem : tab_q;
    alu_b     = alu_sub ? ~w_ext : w_ext;
    alu_res   = {1'b0, alu_a} + {1'b0, alu_b} + (COST_BITS + 1)'(alu_sub);
    alu_sum   = alu_res[COST_BITS-1:0];
    alu_carry = alu_res[COST_BITS];
    cmp_ref   = (state == S_FIN_ACC) ? best_cost : cur_min;
    sum_less  = (alu_sum < cmp_ref);
    tab_inf   = (tab_q == COST_INF);
    back_match = alu_carry && (alu_sum == tab_q);
    best_new  = (!tab_inf && sum_less) ? alu_sum : best_cost;
  end

  // Tour read-out: fixed start, then collected vertices in reverse order
  always_comb begin
    tb_off = count - tour_pos;
    if (tour_pos == '0) begin
      tour_vertex = s_idx;
    end else if (tour_pos <= count) begin
      tour_vertex = tour_buffer[tb_off[VB-1:0]];
    end else begin
      tour_vertex = '0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            s_idx <= VB'(n_minus);
            full  <= ~({SB{1'b1}} << n_minus);
            set   <= SB'(1);
            last  <= '0;
            state <= S_LAST_CHK;
          end
        end
        S_LAST_CHK: begin
          if (!(|(set & last_bit))) begin
            last      <= last_end ? '0 : last + VB'(1);
            set       <= last_end ? set + SB'(1) : set;
            best_cost <= COST_INF;
            state     <= after_last;
          end else if (set == last_bit) begin
            state <= S_SINGLE;
          end else begin
            cur_min <= COST_INF;
            prev    <= '0;
            state   <= S_PREV_CHK;
          end
        end
        S_SINGLE: begin
          cur_min <= w_ext;
          state   <= S_WRITE;
        end
        S_PREV_CHK: begin
          if (|(pre & prev_bit)) begin
            state <= S_PREV_ACC;
          end else if (prev_end) begin
            state <= S_WRITE;
          end else begin
            prev <= prev + VB'(1);
          end
        end
        S_PREV_ACC: begin
          if (!tab_inf && sum_less) begin
            cur_min <= alu_sum;
          end
          if (prev_end) begin
            state <= S_WRITE;
          end else begin
            prev  <= prev + VB'(1);
            state <= S_PREV_CHK;
          end
        end
        S_WRITE: begin
          last      <= last_end ? '0 : last + VB'(1);
          set       <= last_end ? set + SB'(1) : set;
          best_cost <= COST_INF;
          state     <= after_last;
        end
        S_FIN_CHK: begin
          state <= S_FIN_ACC;
        end
        S_FIN_ACC: begin
          best_cost <= best_new;
          if (last_end) begin
            rem       <= best_new;
            remaining <= full;
            tail      <= s_idx;
            count     <= '0;
            pass      <= '0;
            scan      <= '0;
            state     <= S_BACK_CHK;
          end else begin
            last  <= last + VB'(1);
            state <= S_FIN_CHK;
          end
        end
        S_BACK_CHK: begin
          if (remaining == '0 || pass == vertex_total) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (|(remaining & scan_bit)) begin
            state <= S_BACK_CMP;
          end else begin
            scan <= scan_end ? '0 : scan + VB'(1);
            pass <= scan_end ? pass + NB'(1) : pass;
          end
        end
        S_BACK_CMP: begin
          if (back_match) begin
            rem       <= alu_sum;
            remaining <= remaining & ~scan_bit;
            tail      <= scan;
            if (count < NB'(MAX_VERTICES)) begin
              tour_buffer[count[VB-1:0]] <= scan;
              count <= count + NB'(1);
            end
          end
          scan  <= scan_end ? '0 : scan + VB'(1);
          pass  <= scan_end ? pass + NB'(1) : pass;
          state <= S_BACK_CHK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/held_karp_tour_solver.sv =====
// Loading: one distance entry per cycle; the entry marked last starts a solve.
// Solve: the cost-table fill runs every (subset, end, predecessor) step through one
//   table read port, and a walk back through the table then recovers the tour;
//   the input is not ready meanwhile.
// Output: a search for the start vertex, then n beats at one per cycle while the sink is ready.
// Reset (rst, synchronous): n = 16, start vertex 0; matrix and table stay unknown until written.
`default_nettype none

module held_karp_tour_solver #(
  parameter int MAX_VERTICES = hkts_pkg::MAX_VERTICES_DFLT,
  parameter int WEIGHT_BITS  = hkts_pkg::WEIGHT_BITS_DFLT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // from_vertex[3:0], to_vertex[7:4], edge_weight[23:8]
  input  wire logic [hkts_pkg::S_DATA_BITS-1:0]    s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tour_vertex[3:0], tour_length[23:4]
  output logic      [hkts_pkg::M_DATA_BITS-1:0]    m_axis_tdata,
  output logic                                     m_axis_tlast,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [hkts_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [hkts_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int VB        = $clog2(MAX_VERTICES);
  localparam int NB        = $clog2(MAX_VERTICES + 1);
  localparam int COST_BITS = WEIGHT_BITS + VB + 1;
  localparam int WIDE      = (COST_BITS > hkts_pkg::LENGTH_BITS) ? COST_BITS
                                                                 : hkts_pkg::LENGTH_BITS;
  localparam int CMPW      = (VB > hkts_pkg::VERTEX_BITS) ? VB : hkts_pkg::VERTEX_BITS;

  typedef enum logic [1:0] {
    T_LOAD,
    T_SOLVE,
    T_FIND,
    T_EMIT
  } top_state_t;

  top_state_t                              state;
  logic [hkts_pkg::CFG_DATA_BITS-1:0]      vertex_count;
  logic [hkts_pkg::VERTEX_BITS-1:0]        start_vertex;
  logic [NB-1:0]                           k;
  logic [NB-1:0]                           shift;
  logic [hkts_pkg::LENGTH_BITS-1:0]        length;

  logic [hkts_pkg::VERTEX_BITS-1:0]        from_vertex;
  logic [hkts_pkg::VERTEX_BITS-1:0]        to_vertex;
  logic [hkts_pkg::EDGE_BITS-1:0]          edge_weight;
  logic                                    in_acc;
  logic                                    in_range;
  logic [NB-1:0]                           n_clamped;
  logic [NB:0]                             pos_sum;
  logic [NB:0]                             pos_wrap;
  logic [NB-1:0]                           tour_pos;
  logic                                    k_end;
  logic [VB-1:0]                           tour_vertex;
  logic [COST_BITS-1:0]                    best_cost;
  logic [WIDE-1:0]                         best_wide;
  logic                                    solver_done;
  logic                                    start_match;
  hkts_pkg::solve_ctrl_t                   ctrl;

  // Unpack the input beat
  assign from_vertex = s_axis_tdata[hkts_pkg::VERTEX_BITS-1:0];
  assign to_vertex   = s_axis_tdata[2*hkts_pkg::VERTEX_BITS-1:hkts_pkg::VERTEX_BITS];
  assign edge_weight = s_axis_tdata[hkts_pkg::S_DATA_BITS-1:2*hkts_pkg::VERTEX_BITS];

  assign s_axis_tready = (state == T_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_range      = (int'(from_vertex) < MAX_VERTICES) && (int'(to_vertex) < MAX_VERTICES);

  assign ctrl.start = in_acc && s_axis_tlast;
  assign ctrl.wr    = in_acc && in_range;
  assign ctrl.row   = from_vertex;
  assign ctrl.col   = to_vertex;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= hkts_pkg::VERTEX_COUNT_RESET;
      start_vertex <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hkts_pkg::REG_VERTEX_COUNT: vertex_count <= cfg_data;
        hkts_pkg::REG_START_VERTEX: start_vertex <= cfg_data[hkts_pkg::VERTEX_BITS-1:0];
      endcase
    end
  end

  // Clamp the vertex count into the supported range
  always_comb begin
    if (vertex_count < 5'd2) begin
      n_clamped = NB'(2);
    end else if (int'(vertex_count) > MAX_VERTICES) begin
      n_clamped = NB'(MAX_VERTICES);
    end else begin
      n_clamped = NB'(vertex_count);
    end
  end

  // Tour position: scan index while searching, rotated index while emitting
  always_comb begin
    pos_sum  = {1'b0, k} + {1'b0, shift};
    pos_wrap = pos_sum - {1'b0, n_clamped};
    if (state == T_EMIT) begin
      tour_pos = (pos_sum >= {1'b0, n_clamped}) ? pos_wrap[NB-1:0] : pos_sum[NB-1:0];
    end else begin
      tour_pos = k;
    end
  end

  assign k_end       = (k == n_clamped - NB'(1));
  assign start_match = (CMPW'(tour_vertex) == CMPW'(start_vertex));
  assign best_wide   = WIDE'(best_cost);

  hkts_solver #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_solver (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .load_weight  (WEIGHT_BITS'(edge_weight)),
    .vertex_total (n_clamped),
    .tour_pos     (tour_pos),
    .tour_vertex  (tour_vertex),
    .best_cost    (best_cost),
    .done         (solver_done)
  );

  // Front-end sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_LOAD;
      m_axis_tvalid <= 1'b0;
      k             <= '0;
      shift         <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        T_LOAD: begin
          if (in_acc && s_axis_tlast) begin
            state <= T_SOLVE;
          end
        end
        T_SOLVE: begin
          if (solver_done) begin
            length <= (best_wide > WIDE'(hkts_pkg::LEN_MAX)) ? hkts_pkg::LEN_MAX
                                                            : best_wide[hkts_pkg::LENGTH_BITS-1:0];
            k      <= '0;
            state  <= T_FIND;
          end
        end
        T_FIND: begin
          if (start_match) begin
            shift <= k;
            k     <= '0;
            state <= T_EMIT;
          end else if (k_end) begin
            shift <= '0;
            k     <= '0;
            state <= T_EMIT;
          end else begin
            k <= k + NB'(1);
          end
        end
        T_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {length, hkts_pkg::VERTEX_BITS'(tour_vertex)};
            m_axis_tlast  <= k_end;
            if (k_end) begin
              state <= T_LOAD;
            end else begin
              k <= k + NB'(1);
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hkts_checker.sv =====
`default_nettype none
`include "held_karp_tour_solver_assert.svh"

module hkts_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              s_axis_tlast,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [hkts_pkg::M_DATA_BITS-1:0]  m_axis_tdata,
  input wire logic                              m_axis_tlast
);

  // Hold a stalled output beat
  `HKTS_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // Drop input ready once the final entry starts a solve
  `HKTS_ASSERT_NEXT(a_solve_blocks, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

  // Keep the tour going back to back with one length for all beats
  `HKTS_ASSERT_NEXT(a_tour_steady, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[hkts_pkg::M_DATA_BITS-1:hkts_pkg::VERTEX_BITS] == $past(m_axis_tdata[hkts_pkg::M_DATA_BITS-1:hkts_pkg::VERTEX_BITS])))

  // Take no entries while a tour is only partly out
  `HKTS_ASSERT_SAME(a_no_load_mid_tour, clk, rst, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule

bind held_karp_tour_solver hkts_checker u_hkts_checker (.*);

`default_nettype wire
